[hdl/lobm_pkg.sv]
`default_nettype none
package lobm_pkg;
   localparam int BOOK_DEPTH = 32;
   localparam int IDX_W = $clog2(BOOK_DEPTH);
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   localparam logic [2:0] KIND_TRADE    = 3'd0;
   localparam logic [2:0] KIND_FILLED   = 3'd1;
   localparam logic [2:0] KIND_RESTED   = 3'd2;
   localparam logic [2:0] KIND_REJECTED = 3'd3;
   localparam logic [2:0] KIND_FULL     = 3'd4;

   typedef struct packed {
      logic [23:0] price;
      logic [15:0] qty;
      logic [31:0] id;
      logic [31:0] seq;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic             side;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic             rside;
      logic [IDX_W-1:0] raddr;
   } mem_ctl_type;
endpackage
`default_nettype wire

[hdl/limit_order_book_matcher.sv]
// A rejected order gives its status in the cycle after acceptance.
// An accepted order scans the opposite book once per trade, plus a scan
// for the status (one port of the book RAM).
// One order at a time: a new order is accepted only when idle and the response register is free.
// Reset clears valid bits, the arrival counter and max_quantity (to 1000).
`default_nettype none
module limit_order_book_matcher
   import lobm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_side,
   input  wire logic [31:0] req_order_id,
   input  wire logic [23:0] req_price_cents,
   input  wire logic [15:0] req_quantity,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_buy_id,
   output logic [31:0]      rsp_sell_id,
   output logic [23:0]      rsp_trade_price,
   output logic [15:0]      rsp_trade_quantity,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_quantity
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [15:0] maxq_ff;
   logic [31:0] arr_ff;
   logic [BOOK_DEPTH-1:0] bv_ff, av_ff;
   logic        side_ff;
   logic [31:0] id_ff, stamp_ff;
   logic [23:0] price_ff;
   logic [15:0] rem_ff;
   logic [CNT_W-1:0] ntr_ff;
   logic [CNT_W-1:0] scan_ff;
   logic        rd_pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic        have_best_ff;
   logic [IDX_W-1:0] best_ff;
   entry_type   best_e_ff;
   logic        have_free_ff;
   logic [IDX_W-1:0] free_ff;
   logic        rv_ff;
   logic [2:0]  k_ff;
   logic [31:0] b_ff, s_ff;
   logic [23:0] p_ff;
   logic [15:0] q_ff;
   logic        l_ff;

   mem_ctl_type ctl;
   entry_type   rdata;

   lobm_book_ram u_ram (.clock(clock), .ctl(ctl), .rdata(rdata));

   wire [BOOK_DEPTH-1:0] opp_v = side_ff ? bv_ff : av_ff;
   wire [BOOK_DEPTH-1:0] own_v = side_ff ? av_ff : bv_ff;
   wire out_free = !rv_ff || rsp_ready;
   wire req_fire = req_valid && req_ready;

   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_kind = k_ff;
   assign rsp_buy_id = b_ff;
   assign rsp_sell_id = s_ff;
   assign rsp_trade_price = p_ff;
   assign rsp_trade_quantity = q_ff;
   assign rsp_last = l_ff;

   wire better = !have_best_ff ||
      (rdata.price != best_e_ff.price ?
         (side_ff ? rdata.price > best_e_ff.price : rdata.price < best_e_ff.price)
         : rdata.seq < best_e_ff.seq);
   wire crosses = side_ff ? (price_ff <= best_e_ff.price) : (price_ff >= best_e_ff.price);
   wire [15:0] tq = rem_ff < best_e_ff.qty ? rem_ff : best_e_ff.qty;
   wire scan_go = scan_ff < CNT_W'(BOOK_DEPTH);
   wire [IDX_W-1:0] scan_idx = scan_ff[IDX_W-1:0];
   wire done_matching = rem_ff == 16'd0 || ntr_ff == CNT_W'(BOOK_DEPTH);

   always_comb begin
      ctl = '0;
      ctl.rside = !side_ff;
      ctl.raddr = scan_idx;
      ctl.re = (state_ff == S_SCAN) && scan_go && opp_v[scan_idx];
      ctl.side = !side_ff;
      ctl.waddr = best_ff;
      ctl.wdata = best_e_ff;
      ctl.wdata.qty = best_e_ff.qty - tq;
      state_in = state_ff;
      if (state_ff == S_EMIT && out_free) begin
         if (done_matching || !have_best_ff || !crosses) begin
            state_in = S_IDLE;
            if (rem_ff != 16'd0 && have_free_ff) begin
               ctl.we = 1'b1;
               ctl.side = side_ff;
               ctl.waddr = free_ff;
               ctl.wdata = '{price: price_ff, qty: rem_ff, id: id_ff, seq: stamp_ff};
            end
         end else begin
            ctl.we = 1'b1;
            state_in = S_SCAN;
         end
      end
      if (state_ff == S_IDLE && req_fire && req_quantity <= maxq_ff) state_in = S_SCAN;
      if (state_ff == S_SCAN && !scan_go && !rd_pend_ff) state_in = S_EMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         maxq_ff <= 16'd1000;
         arr_ff <= '0;
         bv_ff <= '0;
         av_ff <= '0;
         rv_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) maxq_ff <= csr_max_quantity;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         rd_pend_ff <= ctl.re;
         rd_idx_ff <= scan_idx;
         if (rd_pend_ff && better) begin
            have_best_ff <= 1'b1;
            best_ff <= rd_idx_ff;
            best_e_ff <= rdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  side_ff <= req_side;
                  id_ff <= req_order_id;
                  price_ff <= req_price_cents;
                  rem_ff <= req_quantity;
                  stamp_ff <= arr_ff;
                  ntr_ff <= '0;
                  scan_ff <= '0;
                  have_best_ff <= 1'b0;
                  if (req_quantity > maxq_ff) begin
                     rv_ff <= 1'b1;
                     k_ff <= KIND_REJECTED;
                     b_ff <= req_order_id;
                     s_ff <= '0;
                     p_ff <= '0;
                     q_ff <= req_quantity;
                     l_ff <= 1'b1;
                  end else arr_ff <= arr_ff + 32'd1;
               end
            end
            S_SCAN: begin
               if (scan_go) scan_ff <= scan_ff + CNT_W'(1);
               if (done_matching) scan_ff <= CNT_W'(BOOK_DEPTH);
               have_free_ff <= 1'b0;
               for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
                  if (!own_v[i]) begin
                     have_free_ff <= 1'b1;
                     free_ff <= IDX_W'(i);
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rv_ff <= 1'b1;
                  if (done_matching || !have_best_ff || !crosses) begin
                     l_ff <= 1'b1;
                     b_ff <= id_ff;
                     s_ff <= '0;
                     p_ff <= '0;
                     q_ff <= rem_ff;
                     if (rem_ff == 16'd0) k_ff <= KIND_FILLED;
                     else if (have_free_ff) begin
                        k_ff <= KIND_RESTED;
                        if (side_ff) av_ff[free_ff] <= 1'b1;
                        else bv_ff[free_ff] <= 1'b1;
                     end else k_ff <= KIND_FULL;
                  end else begin
                     l_ff <= 1'b0;
                     k_ff <= KIND_TRADE;
                     b_ff <= side_ff ? best_e_ff.id : id_ff;
                     s_ff <= side_ff ? id_ff : best_e_ff.id;
                     p_ff <= best_e_ff.price;
                     q_ff <= tq;
                     rem_ff <= rem_ff - tq;
                     ntr_ff <= ntr_ff + CNT_W'(1);
                     if (best_e_ff.qty == tq) begin
                        if (side_ff) bv_ff[best_ff] <= 1'b0;
                        else av_ff[best_ff] <= 1'b0;
                     end
                     scan_ff <= '0;
                     have_best_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/lobm_book_ram.sv]
`default_nettype none
module lobm_book_ram
   import lobm_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_ctl_type ctl,
   output entry_type        rdata
);
   entry_type bid_mem [BOOK_DEPTH];
   entry_type ask_mem [BOOK_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         if (ctl.side) ask_mem[ctl.waddr] <= ctl.wdata;
         else bid_mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) rdata <= ctl.rside ? ask_mem[ctl.raddr] : bid_mem[ctl.raddr];
   end
endmodule
`default_nettype wire
